/* src/rtss_pkg.sv */
// Shared types and constants for the round-robin task scheduler.
// No dependencies; every other file in src imports this package.
`default_nettype none

package rtss_pkg;

    localparam int NUM_TASKS = 16;
    localparam int NUM_OBJS  = 8;
    localparam int TICK_BITS = 16;

    localparam int TID_W  = $clog2(NUM_TASKS + 1);
    localparam int RANK_W = $clog2(NUM_TASKS);
    localparam int CNT_W  = $clog2(NUM_TASKS + 1);
    localparam int OBJ_W  = $clog2(NUM_OBJS);
    localparam int IN_OBJ_W = 3;
    localparam int WT_W   = 16;
    localparam int CFG_W  = 64;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [TID_W-1:0]     IDLE_ID      = TID_W'(NUM_TASKS);
    localparam logic [TICK_BITS-1:0] TICK_FOREVER = {TICK_BITS{1'b1}};

    // op codes
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_TICK     = 3'd1;
    localparam logic [2:0] OP_SLEEP    = 3'd2;
    localparam logic [2:0] OP_SEM_WAIT = 3'd3;
    localparam logic [2:0] OP_SEM_POST = 3'd4;
    localparam logic [2:0] OP_LOCK     = 3'd5;
    localparam logic [2:0] OP_UNLOCK   = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_INVALID   = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT   = 2'd2;
    localparam logic [1:0] STAT_NOT_OWNER = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SEM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEM_INI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEM_MAX = 3'd4;

    typedef enum logic [2:0] {
        CLS_START,
        CLS_TICK,
        CLS_SLEEP,
        CLS_SEM_WAIT,
        CLS_SEM_POST,
        CLS_LOCK,
        CLS_UNLOCK,
        CLS_BAD
    } cls_t;

    typedef enum logic [1:0] {
        PL_NONE,
        PL_READY,
        PL_SLEEP,
        PL_WAIT
    } place_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_START,
        ST_TSLEEP,
        ST_TWAIT,
        ST_DISPATCH,
        ST_DONE
    } state_t;

    // decoded item handed from front to back
    typedef struct packed {
        cls_t                 cls;
        logic [OBJ_W-1:0]     obj;
        logic [TICK_BITS-1:0] len;
        logic                 wt_pos;
        logic                 wt_zero;
    } item_t;

endpackage

`default_nettype wire

/* src/rtss_front.sv */
// Front end: decodes an incoming request into an item_t for the back end.
// Depends on rtss_pkg.
`default_nettype none

module rtss_front
    import rtss_pkg::*;
(
    input  wire logic [2:0]          op,
    input  wire logic [IN_OBJ_W-1:0] obj_id,
    input  wire logic [WT_W-1:0]     wait_ticks,
    output item_t                    item
);

    localparam logic [32:0] LEN_LIM = 33'(TICK_FOREVER) - 33'd1;

    logic [32:0] mag;

    always_comb
    begin
        mag = 33'(wait_ticks[WT_W-2:0]);
        item.obj     = OBJ_W'(obj_id);
        item.wt_zero = (wait_ticks == '0);
        item.wt_pos  = !wait_ticks[WT_W-1] && (wait_ticks != '0);
        // negative waits forever; positive is clamped one below forever, a bound its width never reaches
        if (wait_ticks[WT_W-1])
        begin
            item.len = TICK_FOREVER;
        end
        else if (mag > LEN_LIM)
        begin
            item.len = TICK_BITS'(LEN_LIM);
        end
        else
        begin
            item.len = TICK_BITS'(mag);
        end
        unique case (op)
            OP_START:    item.cls = CLS_START;
            OP_TICK:     item.cls = CLS_TICK;
            OP_SLEEP:    item.cls = CLS_SLEEP;
            OP_SEM_WAIT: item.cls = CLS_SEM_WAIT;
            OP_SEM_POST: item.cls = CLS_SEM_POST;
            OP_LOCK:     item.cls = CLS_LOCK;
            OP_UNLOCK:   item.cls = CLS_UNLOCK;
            default:     item.cls = CLS_BAD;
        endcase
    end

endmodule

`default_nettype wire

/* src/rtss_queue.sv */
// Short FIFO of decoded items between front and back end.
// Depends on rtss_pkg.
`default_nettype none

module rtss_queue
    import rtss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire item_t wr_item,
    output logic       full,
    input  wire logic  rd_en,
    output item_t      rd_item,
    output logic       q_empty
);

    item_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + (Q_PTR_W+1)'(wr_en) - (Q_PTR_W+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    assign rd_item = mem[rptr_reg];
    assign full    = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);

endmodule

`default_nettype wire

/* src/rtss_back.sv */
// Back end: scheduler sequencer, per-task cell row, sync objects, result register.
// Depends on rtss_pkg.
`default_nettype none

module rtss_back
    import rtss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  wire item_t                q_item,
    output logic                      q_pop,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [1:0]                status,
    output logic [TID_W-1:0]          running_task,
    output logic                      switched,
    output logic [1:0]                resumed_status,
    output logic                      resumed_valid
);

    // configuration
    logic [NUM_TASKS-1:0]  task_en_reg;
    logic [NUM_OBJS-1:0]   obj_en_reg;
    logic [NUM_OBJS-1:0]   obj_sem_reg;
    logic [CFG_W-1:0]      sem_ini_reg;
    logic [CFG_W-1:0]      sem_max_reg;

    // per-task cells; queue order kept as a rank within the queue
    place_t               place_reg [NUM_TASKS];
    place_t               place_next [NUM_TASKS];
    logic [RANK_W-1:0]    rank_reg [NUM_TASKS];
    logic [RANK_W-1:0]    rank_next [NUM_TASKS];
    logic [TICK_BITS-1:0] ticks_reg [NUM_TASKS];
    logic [TICK_BITS-1:0] ticks_next [NUM_TASKS];
    logic [OBJ_W-1:0]     wobj_reg [NUM_TASKS];
    logic [OBJ_W-1:0]     wobj_next [NUM_TASKS];
    logic                 tout_reg [NUM_TASKS];
    logic                 tout_next [NUM_TASKS];

    // queue lengths
    logic [CNT_W-1:0] ready_cnt_reg, ready_cnt_next;
    logic [CNT_W-1:0] sleep_cnt_reg, sleep_cnt_next;
    logic [CNT_W-1:0] wcnt_reg [NUM_OBJS];
    logic [CNT_W-1:0] wcnt_next [NUM_OBJS];

    // sync objects
    logic [7:0]       cnt_reg [NUM_OBJS];
    logic [7:0]       cnt_next [NUM_OBJS];
    logic [TID_W-1:0] owner_reg [NUM_OBJS];
    logic [TID_W-1:0] owner_next [NUM_OBJS];

    // sequencer
    state_t           state_reg, state_next;
    item_t            item_reg, item_next;
    logic [TID_W-1:0] run_reg, run_next;
    logic [TID_W-1:0] prev_reg, prev_next;
    logic [OBJ_W-1:0] cur_obj_reg, cur_obj_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       stat_reg, stat_next;
    logic             rv_reg, rv_next;
    logic [1:0]       rs_reg, rs_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_stat_reg, out_stat_next;
    logic [TID_W-1:0] out_run_reg, out_run_next;
    logic             out_sw_reg, out_sw_next;
    logic [1:0]       out_rs_reg, out_rs_next;
    logic             out_rv_reg, out_rv_next;

    // cell commands
    place_t               s_place;
    logic [RANK_W-1:0]    s_rank;
    logic                 rm_en;
    logic                 ins_en;
    logic                 ins_head;
    place_t               ins_place;
    logic [TID_W-1:0]     ins_id;
    logic [CNT_W-1:0]     ins_cnt;
    logic                 tk_wr;
    logic [TID_W-1:0]     tk_id;
    logic [TICK_BITS-1:0] tk_val;
    logic                 tout_set;
    logic                 tout_clr;
    logic [TID_W-1:0]     tout_clr_id;
    logic                 clr_all;

    // lookup of (queue, rank)
    logic                 found_hit;
    logic [TID_W-1:0]     found_id;
    logic [TICK_BITS-1:0] found_ticks;
    logic                 found_tout;
    logic [TICK_BITS-1:0] dec_ticks;

    logic cur_is_sem;
    logic want_sem;

    always_comb
    begin
        found_hit   = 1'b0;
        found_id    = '0;
        found_ticks = '0;
        found_tout  = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (s_place != PL_NONE && place_reg[i] == s_place
                && (s_place != PL_WAIT || wobj_reg[i] == cur_obj_reg)
                && rank_reg[i] == s_rank)
            begin
                found_hit   = 1'b1;
                found_id    = found_id | TID_W'(i);
                found_ticks = found_ticks | ticks_reg[i];
                found_tout  = found_tout | tout_reg[i];
            end
        end
        dec_ticks = found_ticks - TICK_BITS'(1);
    end

    always_comb
    begin
        unique case (ins_place)
            PL_READY: ins_cnt = ready_cnt_reg;
            PL_SLEEP: ins_cnt = sleep_cnt_reg;
            PL_WAIT:  ins_cnt = wcnt_reg[cur_obj_reg];
            default:  ins_cnt = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        run_next     = run_reg;
        prev_next    = prev_reg;
        cur_obj_next = cur_obj_reg;
        idx_next     = idx_reg;
        stat_next    = stat_reg;
        rv_next      = rv_reg;
        rs_next      = rs_reg;
        q_pop        = 1'b0;
        s_place      = PL_NONE;
        s_rank       = '0;
        rm_en        = 1'b0;
        ins_en       = 1'b0;
        ins_head     = 1'b0;
        ins_place    = PL_READY;
        ins_id       = run_reg;
        tk_wr        = 1'b0;
        tk_id        = run_reg;
        tk_val       = item_reg.len;
        tout_set     = 1'b0;
        tout_clr     = 1'b0;
        tout_clr_id  = run_reg;
        clr_all      = 1'b0;
        cur_is_sem   = obj_sem_reg[cur_obj_reg];
        want_sem     = (item_reg.cls == CLS_SEM_WAIT) || (item_reg.cls == CLS_SEM_POST);
        for (int k = 0; k < NUM_OBJS; k++)
        begin
            cnt_next[k]   = cnt_reg[k];
            owner_next[k] = owner_reg[k];
        end
        out_valid_next = out_valid_reg && !pop;
        out_stat_next  = out_stat_reg;
        out_run_next   = out_run_reg;
        out_sw_next    = out_sw_reg;
        out_rs_next    = out_rs_reg;
        out_rv_next    = out_rv_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    prev_next    = run_reg;
                    cur_obj_next = q_item.obj;
                    stat_next    = STAT_OK;
                    rv_next      = 1'b0;
                    rs_next      = STAT_OK;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                s_place = PL_WAIT;
                s_rank  = '0;
                state_next = ST_DONE;
                if (item_reg.cls == CLS_START)
                begin
                    clr_all  = 1'b1;
                    run_next = '0;
                    for (int k = 0; k < NUM_OBJS; k++)
                    begin
                        cnt_next[k]   = obj_sem_reg[k] ? sem_ini_reg[k*8 +: 8] : 8'd1;
                        owner_next[k] = IDLE_ID;
                    end
                    idx_next   = CNT_W'(1);
                    state_next = ST_START;
                end
                else if (item_reg.cls == CLS_TICK)
                begin
                    ins_en     = (run_reg != IDLE_ID);
                    idx_next   = sleep_cnt_reg;
                    state_next = ST_TSLEEP;
                end
                else if (item_reg.cls == CLS_BAD || run_reg == IDLE_ID)
                begin
                    stat_next = STAT_INVALID;
                end
                else if (item_reg.cls == CLS_SLEEP)
                begin
                    if (item_reg.wt_pos)
                    begin
                        tk_wr      = 1'b1;
                        ins_en     = 1'b1;
                        ins_place  = PL_SLEEP;
                        state_next = ST_DISPATCH;
                    end
                end
                else if (!obj_en_reg[cur_obj_reg] || cur_is_sem != want_sem)
                begin
                    stat_next = STAT_INVALID;
                end
                else if (item_reg.cls == CLS_SEM_WAIT || item_reg.cls == CLS_LOCK)
                begin
                    if (cnt_reg[cur_obj_reg] != '0)
                    begin
                        cnt_next[cur_obj_reg] = cnt_reg[cur_obj_reg] - 8'd1;
                        if (item_reg.cls == CLS_LOCK)
                        begin
                            owner_next[cur_obj_reg] = run_reg;
                        end
                    end
                    else if (item_reg.wt_zero)
                    begin
                        stat_next = STAT_TIMEOUT;
                    end
                    else
                    begin
                        // caller blocks on the object, next ready task runs
                        tk_wr      = 1'b1;
                        tout_clr   = 1'b1;
                        ins_en     = 1'b1;
                        ins_place  = PL_WAIT;
                        state_next = ST_DISPATCH;
                    end
                end
                else if (item_reg.cls == CLS_UNLOCK && owner_reg[cur_obj_reg] != run_reg)
                begin
                    stat_next = STAT_NOT_OWNER;
                end
                else if (wcnt_reg[cur_obj_reg] == '0)
                begin
                    if (item_reg.cls == CLS_SEM_POST)
                    begin
                        if (cnt_reg[cur_obj_reg] < sem_max_reg[cur_obj_reg*8 +: 8])
                        begin
                            cnt_next[cur_obj_reg] = cnt_reg[cur_obj_reg] + 8'd1;
                        end
                    end
                    else if (cnt_reg[cur_obj_reg] < 8'd1)
                    begin
                        cnt_next[cur_obj_reg] = cnt_reg[cur_obj_reg] + 8'd1;
                    end
                end
                else
                begin
                    // hand over: poster to ready tail, first waiter runs
                    ins_en      = 1'b1;
                    rm_en       = 1'b1;
                    run_next    = found_id;
                    tout_clr    = 1'b1;
                    tout_clr_id = found_id;
                    rv_next     = 1'b1;
                    rs_next     = STAT_OK;
                    if (item_reg.cls == CLS_UNLOCK)
                    begin
                        owner_next[cur_obj_reg] = found_id;
                    end
                end
            end
            ST_START:
            begin
                if (idx_reg == CNT_W'(NUM_TASKS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ins_en   = task_en_reg[idx_reg[RANK_W-1:0]];
                    ins_id   = TID_W'(idx_reg);
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_TSLEEP:
            begin
                // tail to head; removals never disturb lower ranks
                s_place = PL_SLEEP;
                s_rank  = RANK_W'(idx_reg - CNT_W'(1));
                if (idx_reg == '0)
                begin
                    cur_obj_next = '0;
                    state_next   = ST_TWAIT;
                end
                else
                begin
                    tk_wr    = 1'b1;
                    tk_id    = found_id;
                    tk_val   = dec_ticks;
                    idx_next = idx_reg - CNT_W'(1);
                    if (dec_ticks == '0)
                    begin
                        rm_en    = 1'b1;
                        ins_en   = 1'b1;
                        ins_head = 1'b1;
                        ins_id   = found_id;
                    end
                end
            end
            ST_TWAIT:
            begin
                s_place = PL_WAIT;
                s_rank  = idx_reg[RANK_W-1:0];
                if (idx_reg >= wcnt_reg[cur_obj_reg])
                begin
                    idx_next = '0;
                    if (cur_obj_reg == OBJ_W'(NUM_OBJS - 1))
                    begin
                        state_next = ST_DISPATCH;
                    end
                    else
                    begin
                        cur_obj_next = cur_obj_reg + OBJ_W'(1);
                    end
                end
                else if (found_ticks != TICK_FOREVER)
                begin
                    tk_wr  = 1'b1;
                    tk_id  = found_id;
                    tk_val = dec_ticks;
                    if (dec_ticks == '0)
                    begin
                        // timed out: later waiters slide down to this rank
                        rm_en    = 1'b1;
                        tout_set = 1'b1;
                        ins_en   = 1'b1;
                        ins_id   = found_id;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DISPATCH:
            begin
                s_place    = PL_READY;
                s_rank     = '0;
                state_next = ST_DONE;
                if (ready_cnt_reg == '0)
                begin
                    run_next = IDLE_ID;
                end
                else
                begin
                    rm_en    = 1'b1;
                    run_next = found_id;
                    if (found_tout)
                    begin
                        rv_next     = 1'b1;
                        rs_next     = STAT_TIMEOUT;
                        tout_clr    = 1'b1;
                        tout_clr_id = found_id;
                    end
                end
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_stat_next  = stat_reg;
                out_run_next   = run_reg;
                out_sw_next    = (run_reg != prev_reg);
                out_rs_next    = rs_reg;
                out_rv_next    = rv_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cell row and queue lengths
    always_comb
    begin
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            place_next[i] = place_reg[i];
            rank_next[i]  = rank_reg[i];
            ticks_next[i] = ticks_reg[i];
            wobj_next[i]  = wobj_reg[i];
            tout_next[i]  = tout_reg[i];
            if (rm_en && place_reg[i] == s_place
                && (s_place != PL_WAIT || wobj_reg[i] == cur_obj_reg)
                && rank_reg[i] > s_rank)
            begin
                rank_next[i] = rank_reg[i] - RANK_W'(1);
            end
            if (ins_en && ins_head && place_reg[i] == ins_place
                && (ins_place != PL_WAIT || wobj_reg[i] == cur_obj_reg))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
            if (rm_en && found_id == TID_W'(i))
            begin
                place_next[i] = PL_NONE;
            end
            if (ins_en && ins_id == TID_W'(i))
            begin
                place_next[i] = ins_place;
                rank_next[i]  = ins_head ? '0 : ins_cnt[RANK_W-1:0];
                if (ins_place == PL_WAIT)
                begin
                    wobj_next[i] = cur_obj_reg;
                end
            end
            if (tk_wr && tk_id == TID_W'(i))
            begin
                ticks_next[i] = tk_val;
            end
            if (tout_set && found_id == TID_W'(i))
            begin
                tout_next[i] = 1'b1;
            end
            if (tout_clr && tout_clr_id == TID_W'(i))
            begin
                tout_next[i] = 1'b0;
            end
            if (clr_all)
            begin
                place_next[i] = PL_NONE;
                tout_next[i]  = 1'b0;
            end
        end

        ready_cnt_next = ready_cnt_reg
                         + CNT_W'(ins_en && ins_place == PL_READY)
                         - CNT_W'(rm_en && s_place == PL_READY);
        sleep_cnt_next = sleep_cnt_reg
                         + CNT_W'(ins_en && ins_place == PL_SLEEP)
                         - CNT_W'(rm_en && s_place == PL_SLEEP);
        for (int k = 0; k < NUM_OBJS; k++)
        begin
            wcnt_next[k] = wcnt_reg[k];
        end
        wcnt_next[cur_obj_reg] = wcnt_reg[cur_obj_reg]
                                 + CNT_W'(ins_en && ins_place == PL_WAIT)
                                 - CNT_W'(rm_en && s_place == PL_WAIT);
        if (clr_all)
        begin
            ready_cnt_next = '0;
            sleep_cnt_next = '0;
            for (int k = 0; k < NUM_OBJS; k++)
            begin
                wcnt_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_en_reg   <= NUM_TASKS'(1);
            obj_en_reg    <= '0;
            obj_sem_reg   <= '0;
            sem_ini_reg   <= '0;
            sem_max_reg   <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                place_reg[i] <= PL_NONE;
                rank_reg[i]  <= '0;
                ticks_reg[i] <= '0;
                wobj_reg[i]  <= '0;
                tout_reg[i]  <= 1'b0;
            end
            for (int k = 0; k < NUM_OBJS; k++)
            begin
                wcnt_reg[k]  <= '0;
                cnt_reg[k]   <= '0;
                owner_reg[k] <= '0;
            end
            ready_cnt_reg <= '0;
            sleep_cnt_reg <= '0;
            state_reg     <= ST_IDLE;
            run_reg       <= '0;
            prev_reg      <= '0;
            cur_obj_reg   <= '0;
            idx_reg       <= '0;
            stat_reg      <= STAT_OK;
            rv_reg        <= 1'b0;
            rs_reg        <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_TASK_EN: task_en_reg <= cfg_wdata[NUM_TASKS-1:0];
                    CFG_OBJ_EN:  obj_en_reg  <= cfg_wdata[NUM_OBJS-1:0];
                    CFG_OBJ_SEM: obj_sem_reg <= cfg_wdata[NUM_OBJS-1:0];
                    CFG_SEM_INI: sem_ini_reg <= cfg_wdata;
                    CFG_SEM_MAX: sem_max_reg <= cfg_wdata;
                    default:     ;
                endcase
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                place_reg[i] <= place_next[i];
                rank_reg[i]  <= rank_next[i];
                ticks_reg[i] <= ticks_next[i];
                wobj_reg[i]  <= wobj_next[i];
                tout_reg[i]  <= tout_next[i];
            end
            for (int k = 0; k < NUM_OBJS; k++)
            begin
                wcnt_reg[k]  <= wcnt_next[k];
                cnt_reg[k]   <= cnt_next[k];
                owner_reg[k] <= owner_next[k];
            end
            ready_cnt_reg <= ready_cnt_next;
            sleep_cnt_reg <= sleep_cnt_next;
            state_reg     <= state_next;
            run_reg       <= run_next;
            prev_reg      <= prev_next;
            cur_obj_reg   <= cur_obj_next;
            idx_reg       <= idx_next;
            stat_reg      <= stat_next;
            rv_reg        <= rv_next;
            rs_reg        <= rs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_stat_reg <= out_stat_next;
        out_run_reg  <= out_run_next;
        out_sw_reg   <= out_sw_next;
        out_rs_reg   <= out_rs_next;
        out_rv_reg   <= out_rv_next;
    end

    assign empty          = !out_valid_reg;
    assign status         = out_stat_reg;
    assign running_task   = out_run_reg;
    assign switched       = out_sw_reg;
    assign resumed_status = out_rs_reg;
    assign resumed_valid  = out_rv_reg;

    a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_cnt_reg <= CNT_W'(NUM_TASKS))
        else $error("ready queue length out of range");

    a_dispatch_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISPATCH && ready_cnt_reg != '0) |-> found_hit)
        else $error("ready head missing");

    a_sleep_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TSLEEP && idx_reg != '0) |-> found_hit)
        else $error("sleeper rank missing");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !out_valid_reg)
        else $error("result register overwritten");

endmodule

`default_nettype wire

/* src/rtos_task_scheduler_with_sync.sv */
// Top level of the round-robin task scheduler with semaphores and mutexes.
// Depends on rtss_pkg, rtss_front, rtss_queue and rtss_back.
`default_nettype none

// Hardware kernel scheduler. Requests (start, tick, sleep, semaphore wait/post,
// mutex lock/unlock) are pushed in, decoded by the front end into a two-entry
// queue, and executed one at a time by the back-end sequencer, which owns a row
// of per-task cells (queue membership, rank in queue, tick count, timeout flag)
// and the sync object counters. Each request gives exactly one result,
// presented on the output side until popped; a new request is accepted into
// the queue while a result waits. The back-end sequencer touches one queued
// task per cycle: a plain operation passes through execute and done, with a
// dispatch state between them when another task is dispatched from the ready
// queue; start walks every task slot; a tick walks the sleep list, then the
// waiters of each object, then dispatches. Configuration writes take effect
// at once and must only be issued while the block is idle.
module rtos_task_scheduler_with_sync
    import rtss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request side
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [2:0]           op,
    input  wire logic [IN_OBJ_W-1:0]  obj_id,
    input  wire logic [WT_W-1:0]      wait_ticks,
    // result side
    output logic                      empty,
    input  wire logic                 pop,
    output logic [1:0]                status,
    output logic [TID_W-1:0]          running_task,
    output logic                      switched,
    output logic [1:0]                resumed_status,
    output logic                      resumed_valid,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    item_t dec_item;
    item_t q_item;
    logic  q_empty;
    logic  q_pop;
    logic  q_full;

    rtss_front u_front (
        .op         (op),
        .obj_id     (obj_id),
        .wait_ticks (wait_ticks),
        .item       (dec_item)
    );

    // a transfer in happens on push while the queue has room
    rtss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !q_full),
        .wr_item (dec_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .q_empty (q_empty)
    );

    assign full = q_full;

    rtss_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .pop            (pop),
        .empty          (empty),
        .status         (status),
        .running_task   (running_task),
        .switched       (switched),
        .resumed_status (resumed_status),
        .resumed_valid  (resumed_valid)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for rtos_task_scheduler_with_sync: a directed table, then random phases.
// Every result is checked against an in-bench model of the scheduler or a typed expectation.
// Depends on rtss_pkg and the scheduler RTL.
`default_nettype none

module tb_top;
    import rtss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int Q_READY = 0;     // queue slot of the ready list
    localparam int Q_SLEEP = 1;     // sleep list; objects use slots 2..9
    localparam int IDLE = NUM_TASKS;
    localparam int DRAIN_CYCLES = 80;   // covers a tick with every task queued
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [1:0] st;
        logic [4:0] run;
        logic       sw;
        logic [1:0] rs;
        logic       rv;
    } sched_res_t;

    typedef struct packed {
        logic             reconf;  // drain and load the small setup first
        logic [2:0]       op;
        logic [2:0]       obj;
        logic [15:0]      wt;
        logic             chk;     // expectation typed in below
        sched_res_t       res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [2:0] op = '0;
    logic [2:0] obj_id = '0;
    logic [15:0] wait_ticks = '0;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic full, empty, switched, resumed_valid;
    logic [1:0] status, resumed_status;
    logic [TID_W-1:0] running_task;

    rtos_task_scheduler_with_sync i_dut (
        .clk, .rst_n, .push, .full, .op, .obj_id, .wait_ticks,
        .empty, .pop, .status, .running_task, .switched,
        .resumed_status, .resumed_valid, .cfg_we, .cfg_addr, .cfg_wdata
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model state
    logic [15:0] m_task_en;
    logic [7:0]  m_obj_en, m_obj_sem;
    logic [63:0] m_sem_ini, m_sem_max;
    int          m_run;
    int          m_next[NUM_TASKS], m_prev[NUM_TASKS];
    int          m_hd[10], m_tl[10];
    logic [15:0] m_ticks[NUM_TASKS];
    logic        m_tmo[NUM_TASKS];
    logic [7:0]  m_cnt[NUM_OBJS];
    int          m_own[NUM_OBJS];
    logic        m_rv;
    logic [1:0]  m_rs;

    sched_res_t  sched_expected[$];
    int          n_err = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    longint      cycles = 0;

    function automatic void list_append(int q, int t);
        m_next[t] = IDLE;
        m_prev[t] = m_tl[q];
        if (m_tl[q] == IDLE) m_hd[q] = t; else m_next[m_tl[q]] = t;
        m_tl[q] = t;
    endfunction

    function automatic void list_prepend(int q, int t);
        m_prev[t] = IDLE;
        m_next[t] = m_hd[q];
        if (m_hd[q] == IDLE) m_tl[q] = t; else m_prev[m_hd[q]] = t;
        m_hd[q] = t;
    endfunction

    function automatic void list_unlink(int q, int t);
        int n, p;
        n = m_next[t];
        p = m_prev[t];
        if (n == IDLE) m_tl[q] = p; else m_prev[n] = p;
        if (p == IDLE) m_hd[q] = n; else m_next[p] = n;
    endfunction

    function automatic int list_take(int q);
        int t;
        t = m_hd[q];
        if (t != IDLE) list_unlink(q, t);
        return t;
    endfunction

    function automatic void run_task(int t);
        m_run = t;
        if (t != IDLE && m_tmo[t])
        begin
            m_rv = 1'b1;
            m_rs = STAT_TIMEOUT;
            m_tmo[t] = 1'b0;
        end
    endfunction

    function automatic void requeue_running();
        if (m_run != IDLE) list_append(Q_READY, m_run);
    endfunction

    function automatic logic [15:0] ticks_of(logic signed [15:0] w);
        return (w < 0) ? TICK_FOREVER : 16'(w);
    endfunction

    function automatic void hand_to_waiter(int k);
        requeue_running();
        run_task(list_take(2 + k));
        m_rv = 1'b1;
        m_rs = STAT_OK;
    endfunction

    function automatic void model_reset();
        m_task_en = 16'h0001;
        m_obj_en = '0;
        m_obj_sem = '0;
        m_sem_ini = '0;
        m_sem_max = '0;
        m_run = 0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            m_next[i] = 0;
            m_prev[i] = 0;
            m_ticks[i] = '0;
            m_tmo[i] = 1'b0;
        end
        for (int q = 0; q < 10; q++)
        begin
            m_hd[q] = IDLE;
            m_tl[q] = IDLE;
        end
        for (int k = 0; k < NUM_OBJS; k++)
        begin
            m_cnt[k] = '0;
            m_own[k] = 0;
        end
    endfunction

    // Compute the scheduler's answer to one request and advance the model.
    function automatic sched_res_t sched_predict(logic [2:0] o, logic [2:0] k,
                                                 logic signed [15:0] w);
        sched_res_t r;
        int prev, t, p, n;
        logic want_sem;
        logic [1:0] st;
        prev = m_run;
        st = STAT_OK;
        m_rv = 1'b0;
        m_rs = STAT_OK;
        want_sem = (o == OP_SEM_WAIT || o == OP_SEM_POST);
        if (o == OP_START)
        begin
            for (int q = 0; q < 10; q++)
            begin
                m_hd[q] = IDLE;
                m_tl[q] = IDLE;
            end
            for (int i = 0; i < NUM_TASKS; i++) m_tmo[i] = 1'b0;
            for (int i = 1; i < NUM_TASKS; i++)
                if (m_task_en[i]) list_append(Q_READY, i);
            m_run = 0;
            for (int j = 0; j < NUM_OBJS; j++)
            begin
                m_cnt[j] = m_obj_sem[j] ? m_sem_ini[8*j +: 8] : 8'd1;
                m_own[j] = IDLE;
            end
        end
        else if (o == OP_TICK)
        begin
            requeue_running();
            // sleepers walk tail to head, expired ones jump to the ready head
            t = m_tl[Q_SLEEP];
            while (t != IDLE)
            begin
                p = m_prev[t];
                m_ticks[t] = m_ticks[t] - 16'd1;
                if (m_ticks[t] == 0)
                begin
                    list_unlink(Q_SLEEP, t);
                    list_prepend(Q_READY, t);
                end
                t = p;
            end
            for (int j = 0; j < NUM_OBJS; j++)
            begin
                t = m_hd[2 + j];
                while (t != IDLE)
                begin
                    n = m_next[t];
                    if (m_ticks[t] != TICK_FOREVER)
                    begin
                        m_ticks[t] = m_ticks[t] - 16'd1;
                        if (m_ticks[t] == 0)
                        begin
                            list_unlink(2 + j, t);
                            m_tmo[t] = 1'b1;
                            list_append(Q_READY, t);
                        end
                    end
                    t = n;
                end
            end
            run_task(list_take(Q_READY));
        end
        else if (o == OP_UNUSED || m_run == IDLE)
            st = STAT_INVALID;
        else if (o == OP_SLEEP)
        begin
            if (w > 0)
            begin
                m_ticks[m_run] = ticks_of(w);
                list_append(Q_SLEEP, m_run);
                run_task(list_take(Q_READY));
            end
        end
        else if (!m_obj_en[k] || m_obj_sem[k] != want_sem)
            st = STAT_INVALID;
        else if (o == OP_SEM_WAIT || o == OP_LOCK)
        begin
            if (m_cnt[k] > 0)
            begin
                m_cnt[k]--;
                if (o == OP_LOCK) m_own[k] = m_run;
            end
            else if (w == 0)
                st = STAT_TIMEOUT;
            else
            begin
                m_ticks[m_run] = ticks_of(w);
                m_tmo[m_run] = 1'b0;
                list_append(2 + k, m_run);
                run_task(list_take(Q_READY));
            end
        end
        else if (o == OP_SEM_POST)
        begin
            if (m_hd[2 + k] == IDLE)
            begin
                if (m_cnt[k] < m_sem_max[8*k +: 8]) m_cnt[k]++;
            end
            else
                hand_to_waiter(k);
        end
        else
        begin
            if (m_own[k] != m_run)
                st = STAT_NOT_OWNER;
            else if (m_hd[2 + k] == IDLE)
            begin
                if (m_cnt[k] < 1) m_cnt[k]++;
            end
            else
            begin
                hand_to_waiter(k);
                m_own[k] = m_run;
            end
        end
        r.st = st;
        r.run = 5'(m_run);
        r.sw = (m_run != prev);
        r.rs = m_rs;
        r.rv = m_rv;
        return r;
    endfunction

    task automatic report(string what, sched_res_t got, sched_res_t want);
        n_err++;
        $display("mismatch %s: got st=%0d run=%0d sw=%0d rs=%0d rv=%0d, want st=%0d run=%0d sw=%0d rs=%0d rv=%0d",
                 what, got.st, got.run, got.sw, got.rs, got.rv,
                 want.st, want.run, want.sw, want.rs, want.rv);
    endtask

    // One request transfer; the expectation is taken from the model unless given.
    task automatic send_req(logic [2:0] o, logic [2:0] k, logic [15:0] w,
                            logic chk = 1'b0, sched_res_t typed = '0);
        sched_res_t r;
        @(posedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        op <= o;
        obj_id <= k;
        wait_ticks <= w;
        @(negedge clk);
        while (full) @(negedge clk);
        // transfer happens at the coming rising edge
        r = sched_predict(o, k, w);
        sched_expected.push_back(chk ? typed : r);
    endtask

    // Let everything in flight finish, then give the block time to go quiet.
    task automatic drain();
        @(posedge clk);
        push <= 1'b0;
        while (sched_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] a, logic [63:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (a)
            CFG_TASK_EN: m_task_en = d[15:0];
            CFG_OBJ_EN:  m_obj_en = d[7:0];
            CFG_OBJ_SEM: m_obj_sem = d[7:0];
            CFG_SEM_INI: m_sem_ini = d;
            CFG_SEM_MAX: m_sem_max = d;
            default: ;
        endcase
    endtask

    task automatic load_config(logic [15:0] te, logic [7:0] oe, logic [7:0] os,
                               logic [63:0] ini, logic [63:0] mx);
        write_reg(CFG_TASK_EN, 64'(te));
        write_reg(CFG_OBJ_EN, 64'(oe));
        write_reg(CFG_OBJ_SEM, 64'(os));
        write_reg(CFG_SEM_INI, ini);
        write_reg(CFG_SEM_MAX, mx);
    endtask

    function automatic logic [15:0] rand_wait();
        int s;
        s = $urandom_range(9);
        if (s <= 2) return 16'($urandom_range(1, 4));
        if (s == 3) return 16'd0;
        if (s == 4) return 16'hffff;
        if (s == 5) return 16'($urandom);
        return 16'($urandom_range(1, 10));
    endfunction

    function automatic logic [2:0] rand_op();
        int r;
        r = $urandom_range(99);
        if (r < 12) return OP_TICK;
        if (r < 22) return OP_SLEEP;
        if (r < 42) return OP_SEM_WAIT;
        if (r < 60) return OP_SEM_POST;
        if (r < 78) return OP_LOCK;
        if (r < 96) return OP_UNLOCK;
        if (r < 98) return OP_START;
        return OP_UNUSED;
    endfunction

    // Result side: pop is chosen at the rising edge, the transfer is judged
    // at the falling edge when everything is settled.
    initial
    begin
        sched_res_t got, want;
        forever
        begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= stall_pct);
            @(negedge clk);
            if (pop && !empty)
            begin
                got = {status, running_task, switched, resumed_status, resumed_valid};
                if (sched_expected.size() == 0)
                    report("result with nothing expected", got, got);
                else
                begin
                    want = sched_expected.pop_front();
                    if (got.st !== want.st) report("status", got, want);
                    else if (got.run !== want.run) report("running_task", got, want);
                    else if (got.sw !== want.sw) report("switched", got, want);
                    else if (got.rs !== want.rs) report("resumed_status", got, want);
                    else if (got.rv !== want.rv) report("resumed_valid", got, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Directed rows: reset settings first, then a small setup with tasks 0..3,
    // objects 0..3 semaphores and 4..7 mutexes.
    dir_row_t dir_tab[] = '{
        '{1'b0, OP_TICK,     3'd0, 16'd0,    1'b1, '{STAT_OK, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_UNUSED,   3'd7, 16'hffff, 1'b1, '{STAT_INVALID, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SEM_WAIT, 3'd0, 16'd1,    1'b1, '{STAT_INVALID, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_START,    3'd0, 16'd0,    1'b1, '{STAT_OK, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SLEEP,    3'd0, 16'hffff, 1'b1, '{STAT_OK, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SLEEP,    3'd0, 16'd0,    1'b1, '{STAT_OK, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SLEEP,    3'd0, 16'd2,    1'b1, '{STAT_OK, 5'd16, 1'b1, STAT_OK, 1'b0}},
        '{1'b0, OP_SEM_POST, 3'd0, 16'd0,    1'b1, '{STAT_INVALID, 5'd16, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{1'b0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{1'b1, OP_START,    3'd0, 16'd0,    1'b1, '{STAT_OK, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SEM_WAIT, 3'd0, 16'd0,    1'b1, '{STAT_TIMEOUT, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SEM_WAIT, 3'd4, 16'd1,    1'b1, '{STAT_INVALID, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_LOCK,     3'd4, 16'hffff, 1'b1, '{STAT_OK, 5'd0, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_LOCK,     3'd4, 16'hffff, 1'b0, '0},
        '{1'b0, OP_UNLOCK,   3'd4, 16'd0,    1'b1, '{STAT_NOT_OWNER, 5'd1, 1'b0, STAT_OK, 1'b0}},
        '{1'b0, OP_SEM_WAIT, 3'd0, 16'd2,    1'b0, '0},
        '{1'b0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{1'b0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{1'b0, OP_SEM_POST, 3'd1, 16'd0,    1'b0, '0},
        '{1'b0, OP_SEM_POST, 3'd1, 16'd0,    1'b0, '0},
        '{1'b0, OP_UNLOCK,   3'd5, 16'd0,    1'b0, '0},
        '{1'b0, OP_SLEEP,    3'd0, 16'h7fff, 1'b0, '0},
        '{1'b0, OP_SLEEP,    3'd0, 16'h8000, 1'b0, '0},
        '{1'b0, OP_TICK,     3'd0, 16'd0,    1'b0, '0}
    };

    initial
    begin
        int mode;
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].reconf)
            begin
                drain();
                // sem 0 starts empty with max 255, sem 1 saturates at 1
                load_config(16'h000f, 8'hff, 8'h0f,
                            64'h0000_0000_0302_0100, 64'h0000_0000_0303_01ff);
            end
            send_req(dir_tab[i].op, dir_tab[i].obj, dir_tab[i].wt,
                     dir_tab[i].chk, dir_tab[i].res);
        end

        // random phases, each with its own settings; the idling pattern follows the phase number modulo 4
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: load_config(16'hffff, 8'hff, 8'h0f, {$urandom, $urandom}, '1);
                1: load_config(16'($urandom), 8'($urandom), 8'($urandom),
                               {$urandom, $urandom}, {$urandom, $urandom});
                2: load_config('0, '0, '0, '0, '0);
                3: load_config(16'hffff, 8'hff, 8'hff, '0, 64'h0302_0102_0301_0203);
                4: load_config(16'h00ff, 8'hff, 8'h00, '1, '1);
                default: load_config(16'($urandom), 8'hff, 8'($urandom),
                                     {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            mode = ph % 4;
            idle_pct = (mode == 1) ? 49 : (mode == 3) ? 21 : 0;
            stall_pct = (mode == 2) ? 49 : (mode == 3) ? 21 : 0;
            send_req(OP_START, 3'($urandom), 16'($urandom));
            for (int n = 0; n < 250; n++)
                send_req(rand_op(), 3'($urandom), rand_wait());
        end

        drain();
        if (n_err == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/rtss_pkg.sv
src/rtss_front.sv
src/rtss_queue.sv
src/rtss_back.sv
src/rtos_task_scheduler_with_sync.sv
tb/tb_top.sv
